// File: rtl/core/mrwt_pkg.sv
// Shared types for the Miller-Rabin witness test block.
`default_nettype none

package mrwt_pkg;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SPLIT    = 8'b0000_0010,
        S_REDUCE   = 8'b0000_0100,
        S_POW_STEP = 8'b0000_1000,
        S_POW_MUL  = 8'b0001_0000,
        S_POW_SQR  = 8'b0010_0000,
        S_CHECK    = 8'b0100_0000,
        S_SQUARE   = 8'b1000_0000
    } mrwt_state_t;

endpackage

`default_nettype wire

// File: rtl/core/miller_rabin_witness_test.sv
// Top level: one Miller-Rabin round on a candidate and a witness base.
//
//   Channel   Handshake         Payload                              Direction
//   command   start / busy      candidate_number, witness_base       in
//   result    done (strobe)     verdict, decided_trivially           out
//
// A small or even candidate is settled at acceptance and reported on the
// next cycle with busy staying low. Otherwise the round runs on one bit-serial
// modular multiplier: one product reduces the base, then one square per bit
// of d plus one multiply per set bit, then up to r-1 squares. For
// NUMBER_WIDTH=64 that is at most 127 products. Reset clears the sequencer;
// a result strobe cannot be held off by the receiver, and start is ignored
// while busy is high.
`default_nettype none

module miller_rabin_witness_test #(
    parameter int NUMBER_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] candidate_number,
    input  wire logic [63:0] witness_base,
    output logic             done,
    output logic             verdict,
    output logic             decided_trivially
);

    import mrwt_pkg::*;

    localparam int W  = NUMBER_WIDTH;
    localparam int RW = (W > 1) ? $clog2(W) : 1;

    mrwt_state_t   state_reg, state_next;
    logic          done_reg, done_next;
    logic          verdict_reg, verdict_next;
    logic          decided_reg, decided_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  top_reg, top_next;
    logic [W-1:0]  d_reg, d_next;
    logic [RW-1:0] r_reg, r_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  b_reg, b_next;

    logic          mul_go;
    logic [W-1:0]  mul_x;
    logic [W-1:0]  mul_y;
    logic          mul_done;
    logic [W-1:0]  mul_prod;

    logic [W-1:0]  n_in;
    logic [W-1:0]  one;

    assign n_in = candidate_number[W-1:0];
    assign one  = {{(W-1){1'b0}}, 1'b1};

    // Shared modular multiplier
    mrwt_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .x     (mul_x),
        .y     (mul_y),
        .m     (n_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Sequence the round
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        verdict_next = verdict_reg;
        decided_next = decided_reg;
        n_next       = n_reg;
        a_next       = a_reg;
        top_next     = top_reg;
        d_next       = d_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        b_next       = b_reg;
        mul_go       = 1'b0;
        mul_x        = acc_reg;
        mul_y        = b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = n_in;
                    a_next = witness_base[W-1:0];
                    if (n_in[W-1:1] == '0)
                    begin
                        // below two: composite
                        done_next    = 1'b1;
                        verdict_next = 1'b0;
                        decided_next = 1'b1;
                    end
                    else if (n_in[W-1:2] == '0)
                    begin
                        // two or three: prime
                        done_next    = 1'b1;
                        verdict_next = 1'b1;
                        decided_next = 1'b1;
                    end
                    else if (!n_in[0])
                    begin
                        // even: composite
                        done_next    = 1'b1;
                        verdict_next = 1'b0;
                        decided_next = 1'b1;
                    end
                    else
                    begin
                        top_next   = n_in - one;
                        d_next     = n_in - one;
                        r_next     = '0;
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT:
            begin
                // strip factors of two from n-1
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    mul_go     = 1'b1;
                    mul_x      = one;
                    mul_y      = a_reg;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mul_done)
                begin
                    b_next     = mul_prod;
                    acc_next   = one;
                    state_next = S_POW_STEP;
                end
            end
            S_POW_STEP:
            begin
                if (d_reg == '0)
                begin
                    state_next = S_CHECK;
                end
                else if (d_reg[0])
                begin
                    mul_go     = 1'b1;
                    mul_x      = acc_reg;
                    mul_y      = b_reg;
                    state_next = S_POW_MUL;
                end
                else
                begin
                    mul_go     = 1'b1;
                    mul_x      = b_reg;
                    mul_y      = b_reg;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_prod;
                    mul_go     = 1'b1;
                    mul_x      = b_reg;
                    mul_y      = b_reg;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_SQR:
            begin
                if (mul_done)
                begin
                    b_next     = mul_prod;
                    d_next     = {1'b0, d_reg[W-1:1]};
                    state_next = S_POW_STEP;
                end
            end
            S_CHECK:
            begin
                if (acc_reg == one || acc_reg == top_reg)
                begin
                    done_next    = 1'b1;
                    verdict_next = 1'b1;
                    decided_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else if (r_reg[RW-1:1] == '0)
                begin
                    done_next    = 1'b1;
                    verdict_next = 1'b0;
                    decided_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    r_next     = r_reg - 1'b1;
                    mul_go     = 1'b1;
                    mul_x      = acc_reg;
                    mul_y      = acc_reg;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (mul_done)
                begin
                    acc_next = mul_prod;
                    if (mul_prod == top_reg)
                    begin
                        done_next    = 1'b1;
                        verdict_next = 1'b1;
                        decided_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else if (r_reg == RW'(1))
                    begin
                        done_next    = 1'b1;
                        verdict_next = 1'b0;
                        decided_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        r_next = r_reg - 1'b1;
                        mul_go = 1'b1;
                        mul_x  = mul_prod;
                        mul_y  = mul_prod;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            verdict_reg <= 1'b0;
            decided_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            verdict_reg <= verdict_next;
            decided_reg <= decided_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        a_reg   <= a_next;
        top_reg <= top_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign verdict           = verdict_reg;
    assign decided_trivially = decided_reg;

endmodule

`default_nettype wire

// File: rtl/core/mrwt_mulmod.sv
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle, MSB first.
`default_nettype none

module mrwt_mulmod #(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      prod
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          running_reg, running_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;

    logic [W:0]    dbl;
    logic [W:0]    dbl_sub;
    logic [W-1:0]  dbl_mod;
    logic [W:0]    sum;
    logic [W:0]    sum_sub;
    logic [W-1:0]  step_mod;

    // Double the accumulator mod m, then add x mod m when the current bit of y is set
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_sub  = dbl - {1'b0, m};
        dbl_mod  = (dbl >= {1'b0, m}) ? dbl_sub[W-1:0] : dbl[W-1:0];
        sum      = {1'b0, dbl_mod} + {1'b0, x_reg};
        sum_sub  = sum - {1'b0, m};
        step_mod = dbl_mod;
        if (y_reg[W-1])
        begin
            step_mod = (sum >= {1'b0, m}) ? sum_sub[W-1:0] : sum[W-1:0];
        end
    end

    // Sequence the W steps of one product
    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        if (go)
        begin
            running_next = 1'b1;
            cnt_next     = CW'(W - 1);
            acc_next     = '0;
            x_next       = x;
            y_next       = y;
        end
        else if (running_reg)
        begin
            acc_next = step_mod;
            y_next   = {y_reg[W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Hold operands and accumulator
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/mrwt_checker.sv
// Port-level checks for the Miller-Rabin witness test block, with its bind.
`default_nettype none

module mrwt_checker #(
    parameter int W = 64
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [63:0] candidate_number,
    input wire logic [63:0] witness_base,
    input wire logic        done,
    input wire logic        verdict,
    input wire logic        decided_trivially
);

    logic          accept;
    logic [W-1:0]  n_in;

    assign accept = start && !busy;
    assign n_in   = candidate_number[W-1:0];

    // Even candidates of four or more report composite on the next cycle
    a_even_composite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !n_in[0] && n_in[W-1:2] != '0)
            |=> (done && decided_trivially && !verdict && !busy))
        else $error("even candidate not settled as composite");

    // Two and three report prime on the next cycle
    a_small_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && n_in[W-1:2] == '0 && n_in[1])
            |=> (done && decided_trivially && verdict))
        else $error("two or three not settled as prime");

    // Odd candidates of five or more start a full round
    a_odd_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && n_in[0] && n_in[W-1:2] != '0) |=> busy)
        else $error("odd candidate did not start a round");

    // The end of a round comes with its result
    a_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && !decided_trivially))
        else $error("round ended without a result");

    // A round result is never shown while busy
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !decided_trivially) |-> !busy)
        else $error("round result while busy");

endmodule

bind miller_rabin_witness_test mrwt_checker #(
    .W (NUMBER_WIDTH)
) u_mrwt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .candidate_number  (candidate_number),
    .witness_base      (witness_base),
    .done              (done),
    .verdict           (verdict),
    .decided_trivially (decided_trivially)
);

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the Miller-Rabin witness test block.
`timescale 1ns / 100ps

module tb;

    localparam int          NUMBER_WIDTH  = 64;
    localparam logic [63:0] NUMBER_MASK   = (NUMBER_WIDTH >= 64) ? ~64'd0
                                          : ((64'd1 << NUMBER_WIDTH) - 64'd1);
    localparam int          STALL_LIMIT   = 60000;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          RANDOM_ROUNDS = 100;

    typedef struct packed {
        logic verdict;
        logic decided_trivially;
    } round_verdict_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] candidate_number;
    logic [63:0] witness_base;
    logic        done;
    logic        verdict;
    logic        decided_trivially;

    round_verdict_t pending_verdicts[$];
    int             error_count;
    int             idle_cycles;
    int             trivial_count;
    int             round_count;
    int             prime_count;

    miller_rabin_witness_test #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .candidate_number  (candidate_number),
        .witness_base      (witness_base),
        .done              (done),
        .verdict           (verdict),
        .decided_trivially (decided_trivially)
    );

    // Free-running 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Exact (x * y) mod m through a double-width product
    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        return 64'(prod % {64'd0, m});
    endfunction

    // Expected verdict of one witness round
    function automatic round_verdict_t miller_rabin_round(logic [63:0] n_in,
                                                          logic [63:0] a_in);
        round_verdict_t res;
        logic [63:0]    n;
        logic [63:0]    n_minus_1;
        logic [63:0]    odd_part;
        logic [63:0]    exp_bits;
        logic [63:0]    base;
        logic [63:0]    x;
        int             twos;
        n = n_in & NUMBER_MASK;
        res.decided_trivially = 1'b1;
        res.verdict = 1'b0;
        if (n < 64'd2)
            return res;
        if (n == 64'd2 || n == 64'd3)
        begin
            res.verdict = 1'b1;
            return res;
        end
        if (!n[0])
            return res;
        res.decided_trivially = 1'b0;
        n_minus_1 = n - 64'd1;
        odd_part = n_minus_1;
        twos = 0;
        while (!odd_part[0])
        begin
            odd_part = odd_part >> 1;
            twos++;
        end
        // Raise the reduced base to the odd part of n-1
        base = (a_in & NUMBER_MASK) % n;
        x = 64'd1;
        exp_bits = odd_part;
        while (exp_bits != 64'd0)
        begin
            if (exp_bits[0])
                x = mul_mod(x, base, n);
            base = mul_mod(base, base, n);
            exp_bits = exp_bits >> 1;
        end
        if (x == 64'd1 || x == n_minus_1)
        begin
            res.verdict = 1'b1;
            return res;
        end
        // Square up to r-1 times looking for n-1
        for (int j = 1; j < twos; j++)
        begin
            x = mul_mod(x, x, n);
            if (x == n_minus_1)
            begin
                res.verdict = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(50, 300);
    endfunction

    // Send one transaction and record its expected verdict at acceptance
    task automatic issue_round(logic [63:0] n, logic [63:0] a, int gap);
        round_verdict_t predicted;
        for (int i = 0; i < gap; i++)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start            <= 1'b1;
        candidate_number <= n;
        witness_base     <= a;
        do
            @(posedge clk);
        while (busy);
        predicted = miller_rabin_round(n, a);
        pending_verdicts.push_back(predicted);
        if (predicted.decided_trivially)
            trivial_count++;
        else
            round_count++;
        if (predicted.verdict && !predicted.decided_trivially)
            prime_count++;
    endtask

    // Hold the sender until every outstanding verdict has come back
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Candidates below four and even ones
    task automatic test_small_and_even();
        issue_round(64'd0, rand64(), pick_gap());
        issue_round(64'd1, rand64(), pick_gap());
        issue_round(64'd2, 64'd0, pick_gap());
        issue_round(64'd3, ~64'd0, pick_gap());
        issue_round(64'd4, 64'd5, pick_gap());
        issue_round(64'hFFFF_FFFF_FFFF_FFFE, rand64(), pick_gap());
    endtask

    // Bases at zero, multiples of n, one and n-1, plus known pseudoprimes
    task automatic test_edge_bases();
        issue_round(64'd97, 64'd0, pick_gap());
        issue_round(64'd97, 64'd97, pick_gap());
        issue_round(64'd97, 64'd1, pick_gap());
        issue_round(64'd97, 64'd96, pick_gap());
        issue_round(64'd97, 64'd98, pick_gap());
        issue_round(64'd97, 64'd2, pick_gap());
        issue_round(64'd2047, 64'd2, pick_gap());
        issue_round(64'd561, 64'd2, pick_gap());
        issue_round(64'd25, 64'd7, pick_gap());
        issue_round(64'd5, 64'd4, pick_gap());
    endtask

    // Full-width candidates, where a narrow product would overflow
    task automatic test_wide_candidates();
        issue_round(64'h1FFF_FFFF_FFFF_FFFF, 64'd3, pick_gap());
        issue_round(64'hFFFF_FFFF_FFFF_FFC5, ~64'd0, pick_gap());
        issue_round(64'hFFFF_FFFF_FFFF_FFFF, 64'd2, pick_gap());
        issue_round(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC5, pick_gap());
    endtask

    // Trivial candidates with no gap, so results and acceptances overlap
    task automatic test_back_to_back_trivial();
        for (int i = 0; i < 4; i++)
            issue_round(rand64() & ~64'd1, rand64(), 0);
    endtask

    function automatic logic [63:0] pick_small_prime();
        case ($urandom_range(0, 7))
            0:       return 64'd5;
            1:       return 64'd7;
            2:       return 64'd13;
            3:       return 64'd31;
            4:       return 64'd101;
            5:       return 64'd7919;
            6:       return 64'd65537;
            default: return 64'd2147483647;
        endcase
    endfunction

    // Random rounds, mostly small odd candidates, with one full drain midway
    task automatic test_random_rounds();
        logic [63:0] n;
        logic [63:0] a;
        int          sel;
        int          bits;
        for (int i = 0; i < RANDOM_ROUNDS; i++)
        begin
            if (i == RANDOM_ROUNDS / 2)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                n = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 3))
                                                : (rand64() & ~64'd1);
            end
            else if (sel < 20)
                n = rand64() | 64'h8000_0000_0000_0001;
            else if (sel < 30)
                n = pick_small_prime();
            else
            begin
                bits = $urandom_range(3, 24);
                n = (rand64() & ((64'd1 << bits) - 64'd1)) | (64'd1 << (bits - 1)) | 64'd1;
                if (n < 64'd5)
                    n = 64'd5;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70 || n < 64'd4)
                a = rand64();
            else if (sel < 78)
                a = n - 64'd1;
            else if (sel < 84)
                a = 64'd1;
            else if (sel < 90)
                a = (n[63:32] != 32'd0) ? n : n * 64'($urandom_range(0, 1000));
            else
                a = rand64() % n;
            issue_round(n, a, pick_gap());
        end
    endtask

    // Compare each result with the oldest expectation; watch for a hang
    always @(posedge clk)
    begin
        round_verdict_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result verdict=%0b decided_trivially=%0b",
                             $time, verdict, decided_trivially);
                    error_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $display("%0t: verdict mismatch expected %0b actual %0b",
                                 $time, want.verdict, verdict);
                        error_count++;
                    end
                    if (decided_trivially !== want.decided_trivially)
                    begin
                        $display("%0t: decided_trivially mismatch expected %0b actual %0b",
                                 $time, want.decided_trivially, decided_trivially);
                        error_count++;
                    end
                end
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("miller_rabin_witness_test verification failed");
                $finish;
            end
        end
    end

    // Reset, run each test in turn, drain and report
    initial
    begin
        error_count      = 0;
        idle_cycles      = 0;
        trivial_count    = 0;
        round_count      = 0;
        prime_count      = 0;
        rst_n            = 1'b0;
        start            = 1'b0;
        candidate_number = 64'd0;
        witness_base     = 64'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_small_and_even();
        test_edge_bases();
        test_wide_candidates();
        test_back_to_back_trivial();
        test_random_rounds();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_verdicts.size());
            error_count++;
        end

        $display("Ran %0d exponentiation rounds (%0d probably prime) and %0d trivial candidates,",
                 round_count, prime_count, trivial_count);
        $display("including edge bases, pseudoprimes, full-width primes and one drain pause.");
        if (error_count == 0)
            $display("miller_rabin_witness_test verification clean");
        else
            $display("miller_rabin_witness_test verification failed");
        $finish;
    end

endmodule
